/* design/dts_pkg.sv */
`timescale 1ns / 1ps

package dts_pkg;

  // Scanner mode between characters
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_IDENT = 2'd2
  } mode_e;

  // Token codes
  localparam logic [4:0] TK_EOI      = 5'd0;
  localparam logic [4:0] TK_UNKNOWN  = 5'd1;
  localparam logic [4:0] TK_STAR     = 5'd2;
  localparam logic [4:0] TK_QUEST    = 5'd3;
  localparam logic [4:0] TK_PLUS     = 5'd4;
  localparam logic [4:0] TK_BAR      = 5'd5;
  localparam logic [4:0] TK_EQUAL    = 5'd6;
  localparam logic [4:0] TK_LPAREN   = 5'd7;
  localparam logic [4:0] TK_RPAREN   = 5'd8;
  localparam logic [4:0] TK_LBRACKET = 5'd9;
  localparam logic [4:0] TK_RBRACKET = 5'd10;
  localparam logic [4:0] TK_LBRACE   = 5'd11;
  localparam logic [4:0] TK_RBRACE   = 5'd12;
  localparam logic [4:0] TK_COMMA    = 5'd13;
  localparam logic [4:0] TK_SEMI     = 5'd14;
  localparam logic [4:0] TK_PLAYERS  = 5'd15;
  localparam logic [4:0] TK_PIECES   = 5'd16;
  localparam logic [4:0] TK_BSIZE    = 5'd17;
  localparam logic [4:0] TK_BOARD    = 5'd18;
  localparam logic [4:0] TK_RULE     = 5'd19;
  localparam logic [4:0] TK_MACRO    = 5'd20;
  localparam logic [4:0] TK_POST     = 5'd21;
  localparam logic [4:0] TK_NUMBER   = 5'd22;
  localparam logic [4:0] TK_IDENT    = 5'd23;

  // Keyword table, text left-justified and zero padded
  localparam int NUM_KW     = 7;
  localparam int KW_MAX_LEN = 10;

  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KW] = '{
    {"players", 24'h0},
    {"pieces", 32'h0},
    {"board", "_size"},
    {"board", 40'h0},
    {"rule", 48'h0},
    {"macro", 40'h0},
    {"post", 48'h0}
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd7, 4'd6, 4'd10, 4'd5, 4'd4, 4'd5, 4'd4
  };
  localparam logic [4:0] KW_CODE [NUM_KW] = '{
    TK_PLAYERS, TK_PIECES, TK_BSIZE, TK_BOARD, TK_RULE, TK_MACRO, TK_POST
  };

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [4:0]  code;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic [7:0]  first_char;
  } result_t;

  // One queued item: an optional closing token and an optional character token
  typedef struct packed {
    logic    has_close;
    logic    has_char;
    result_t close_r;
    result_t char_r;
  } entry_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [4:0] punct_code(logic [7:0] c);
    logic [4:0] code;
    unique case (c)
      8'h2A:   code = TK_STAR;
      8'h3F:   code = TK_QUEST;
      8'h2B:   code = TK_PLUS;
      8'h7C:   code = TK_BAR;
      8'h3D:   code = TK_EQUAL;
      8'h28:   code = TK_LPAREN;
      8'h29:   code = TK_RPAREN;
      8'h5B:   code = TK_LBRACKET;
      8'h5D:   code = TK_RBRACKET;
      8'h7B:   code = TK_LBRACE;
      8'h7D:   code = TK_RBRACE;
      8'h2C:   code = TK_COMMA;
      8'h3B:   code = TK_SEMI;
      default: code = TK_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

/* design/dts_front.sv */
`timescale 1ns / 1ps

module dts_front #(
  parameter int KEYWORD_CHARS = 10,
  parameter int COUNTER_BITS  = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      char_byte_i,
  output logic            in_stall_o,
  input  logic            full_i,
  output logic            push_valid_o,
  output dts_pkg::entry_t push_entry_o
);
  import dts_pkg::*;

  localparam int CW    = COUNTER_BITS;
  localparam int IDX_W = $clog2(KEYWORD_CHARS);

  mode_e         mode_q, mode_d;
  logic [CW-1:0] line_q, line_d;
  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] tok_line_q, tok_line_d;
  logic [CW-1:0] tok_col_q, tok_col_d;
  logic [CW-1:0] tok_len_q, tok_len_d;
  logic          kw_ovf_q, kw_ovf_d;
  logic [7:0]    kw_buf_q [KEYWORD_CHARS];

  logic             buf_we;
  logic [IDX_W-1:0] buf_widx;
  logic             accept;
  logic [4:0]       ident_code;
  entry_t           entry;

  function automatic logic [CW-1:0] sat_inc(logic [CW-1:0] v);
    return (v == {CW{1'b1}}) ? v : v + CW'(1);
  endfunction

  function automatic logic [15:0] clamp16(logic [CW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (|w[31:16]) ? 16'hFFFF : w[15:0];
  endfunction

  // Stall input while the queue has no room
  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;

  // Match the buffered identifier against the keyword table
  always_comb begin
    logic match;
    logic found;
    ident_code = TK_IDENT;
    found      = 1'b0;
    for (int i = 0; i < NUM_KW; i++) begin
      match = (32'(tok_len_q) == 32'(KW_LEN[i]));
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if ((j < int'(KW_LEN[i])) &&
            (kw_buf_q[IDX_W'(j)] != KW_TEXT[i][8*KW_MAX_LEN-1-8*j -: 8])) begin
          match = 1'b0;
        end
      end
      if (match && !found && !kw_ovf_q) begin
        ident_code = KW_CODE[i];
        found      = 1'b1;
      end
    end
  end

  // Advance location, track the open token and classify the character
  always_comb begin
    logic [7:0]    c;
    logic [CW-1:0] line_n;
    logic [CW-1:0] col_n;
    logic          cont;
    c            = char_byte_i;
    mode_d       = mode_q;
    line_d       = line_q;
    col_d        = col_q;
    tok_line_d   = tok_line_q;
    tok_col_d    = tok_col_q;
    tok_len_d    = tok_len_q;
    kw_ovf_d     = kw_ovf_q;
    buf_we       = 1'b0;
    buf_widx     = tok_len_q[IDX_W-1:0];
    entry        = '0;
    cont         = 1'b0;
    line_n       = line_q;
    col_n        = col_q;

    if (c != CH_NUL) begin
      if (c == CH_LF) begin
        line_n = sat_inc(line_q);
        col_n  = '0;
      end else begin
        col_n = sat_inc(col_q);
      end
    end

    if (accept) begin
      line_d = line_n;
      col_d  = col_n;

      // Extend or close the open token
      unique case (mode_q)
        MODE_NUM: begin
          if (is_digit(c)) begin
            cont      = 1'b1;
            tok_len_d = sat_inc(tok_len_q);
          end else begin
            entry.has_close      = 1'b1;
            entry.close_r.code   = TK_NUMBER;
          end
        end
        MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c) || (c == CH_MINUS) || (c == CH_UNDER)) begin
            cont = 1'b1;
            if (32'(tok_len_q) < 32'(KEYWORD_CHARS)) begin
              buf_we = 1'b1;
            end else begin
              kw_ovf_d = 1'b1;
            end
            tok_len_d = sat_inc(tok_len_q);
          end else begin
            entry.has_close    = 1'b1;
            entry.close_r.code = ident_code;
          end
        end
        default: ;
      endcase
      entry.close_r.line       = clamp16(tok_line_q);
      entry.close_r.column     = clamp16(tok_col_q);
      entry.close_r.length     = clamp16(tok_len_q);
      entry.close_r.first_char = '0;

      // Classify a character that is not part of the open token
      entry.char_r.line   = clamp16(line_n);
      entry.char_r.column = clamp16(col_n);
      if (!cont) begin
        mode_d = MODE_IDLE;
        if (c == CH_NUL) begin
          entry.has_char = 1'b1;
          entry.char_r.code = TK_EOI;
        end else if (is_space(c)) begin
          mode_d = MODE_IDLE;
        end else if (is_digit(c) || (c == CH_MINUS)) begin
          mode_d     = MODE_NUM;
          tok_line_d = line_n;
          tok_col_d  = col_n;
          tok_len_d  = CW'(1);
        end else if (is_alpha(c)) begin
          mode_d     = MODE_IDENT;
          tok_line_d = line_n;
          tok_col_d  = col_n;
          tok_len_d  = CW'(1);
          kw_ovf_d   = 1'b0;
          buf_we     = 1'b1;
          buf_widx   = '0;
        end else begin
          entry.has_char            = 1'b1;
          entry.char_r.code         = punct_code(c);
          entry.char_r.length       = 16'd1;
          entry.char_r.first_char   = c;
        end
      end
    end
  end

  assign push_valid_o = accept & (entry.has_close | entry.has_char);
  assign push_entry_o = entry;

  // Hold scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      line_q     <= CW'(1);
      col_q      <= '0;
      tok_line_q <= '0;
      tok_col_q  <= '0;
      tok_len_q  <= '0;
      kw_ovf_q   <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      line_q     <= line_d;
      col_q      <= col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      tok_len_q  <= tok_len_d;
      kw_ovf_q   <= kw_ovf_d;
    end
  end

  // Keyword buffer: written by the current identifier only
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      kw_buf_q[buf_widx] <= char_byte_i;
    end
  end

endmodule

/* design/dts_queue.sv */
`timescale 1ns / 1ps

module dts_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  dts_pkg::entry_t push_entry_i,
  output logic            full_o,
  output logic            head_valid_o,
  output dts_pkg::entry_t head_entry_o,
  input  logic            pop_i
);
  import dts_pkg::*;

  entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push, do_pop;

  assign full_o       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QPTR_W+1)'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* design/dts_back.sv */
`timescale 1ns / 1ps

module dts_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  dts_pkg::entry_t head_entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output dts_pkg::result_t out_res_o,
  output logic            out_last_o
);
  import dts_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    phase_q, phase_d;
  result_t out_res_q, out_res_d;
  logic    out_last_q, out_last_d;
  logic    load;

  // Drain the head entry one result per cycle, while the output is not stalled, into the output register
  always_comb begin
    load        = ~out_valid_q | ~out_stall_i;
    out_valid_d = out_valid_q;
    phase_d     = phase_q;
    out_res_d   = out_res_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        if (head_entry_i.has_close && !phase_q) begin
          out_res_d  = head_entry_i.close_r;
          out_last_d = ~head_entry_i.has_char;
          if (head_entry_i.has_char) begin
            phase_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          out_res_d  = head_entry_i.char_r;
          out_last_d = 1'b1;
          pop_o      = 1'b1;
          phase_d    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_last_o  = out_last_q;

  // A half-drained entry stays at the queue head
  a_phase_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> head_valid_i)
    else $error("second half pending without queue head");

  // End of input is always the final result of its item and has no length
  a_eoi_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_res_q.code == TK_EOI)) |-> (out_last_q && (out_res_q.length == '0)))
    else $error("EOI result malformed");

  // Single-character tokens are one character long
  a_punct_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_res_q.code >= TK_UNKNOWN) && (out_res_q.code <= TK_SEMI))
      |-> (out_res_q.length == 16'd1))
    else $error("punctuation length not one");

endmodule

/* design/dsl_token_scanner.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// input    in         in_valid_i/in_stall_o   char_byte_i
// output   out        out_valid_o/out_stall_i token_code_o, start_line_o, start_column_o,
//                                             token_length_o, first_char_o, last_of_run_o
//
// One character is taken per cycle while in_stall_o is low; each gives zero, one or two results.
// The output side delivers one result per cycle while out_stall_i is low, so an item with two
// results drains more slowly than it is taken in; a four-entry queue between front and back absorbs this.
// The first result passes through the queue and then the output register before it is valid.
// Reset (rst_ni low, asynchronous) returns to idle at line 1, column 0.
// in_stall_o is high only while the queue is full.

module dsl_token_scanner #(
  parameter int KEYWORD_CHARS = 10,
  parameter int COUNTER_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_code_o,
  output logic [15:0] start_line_o,
  output logic [15:0] start_column_o,
  output logic [15:0] token_length_o,
  output logic [7:0]  first_char_o,
  output logic        last_of_run_o
);
  import dts_pkg::*;

  logic    push_valid;
  entry_t  push_entry;
  logic    full;
  logic    head_valid;
  entry_t  head_entry;
  logic    pop;
  result_t out_res;

  dts_front #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .char_byte_i (char_byte_i),
    .in_stall_o  (in_stall_o),
    .full_i      (full),
    .push_valid_o(push_valid),
    .push_entry_o(push_entry)
  );

  dts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_entry_i(push_entry),
    .full_o      (full),
    .head_valid_o(head_valid),
    .head_entry_o(head_entry),
    .pop_i       (pop)
  );

  dts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_entry_i(head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res),
    .out_last_o  (last_of_run_o)
  );

  assign token_code_o   = out_res.code;
  assign start_line_o   = out_res.line;
  assign start_column_o = out_res.column;
  assign token_length_o = out_res.length;
  assign first_char_o   = out_res.first_char;

endmodule
